### hdl/zswf_pkg.sv
// Shared constants, codes and types of the zero square window finder.
package zswf_pkg;

  // Largest matrix side held by the column delay chain
  localparam int MAX_DIM = 32;

  // Position counter width and width of a clamped dimension
  localparam int POS_W = $clog2(MAX_DIM);
  localparam int CNT_W = $clog2(MAX_DIM + 1);

  // Configuration register width and column run width
  localparam int CFG_W = 6;
  localparam int RUN_W = CFG_W;

  // Fixed field widths of the streams
  localparam int CELL_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int OUT_POS_W = 5;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;
  localparam int REG_IDX_W  = 2;

  // Register reset values
  localparam logic [CFG_W-1:0] ROW_COUNT_RST    = CFG_W'(8);
  localparam logic [CFG_W-1:0] COLUMN_COUNT_RST = CFG_W'(8);
  localparam logic [CFG_W-1:0] SQUARE_SIZE_RST  = CFG_W'(3);

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_COLUMN_COUNT = 2'd1,
    REG_SQUARE_SIZE  = 2'd2
  } reg_idx_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_END_FOUND = 2'd1,
    STATUS_END_NONE  = 2'd2,
    STATUS_TOO_LARGE = 2'd3
  } status_t;

  // One result item handed to the output stage
  typedef struct packed {
    status_t                status;
    logic [OUT_POS_W-1:0]   top_row;
    logic [OUT_POS_W-1:0]   left_column;
    logic                   matrix_done;
  } result_t;

endpackage

### hdl/zswf_cell.sv
// One cell of the column delay chain: holds the zero-run length of one column.
module zswf_cell
  import zswf_pkg::*;
(
  input  logic             clk,
  input  logic             shift,
  input  logic [RUN_W-1:0] run_in,
  output logic [RUN_W-1:0] run_out
);

  logic [RUN_W-1:0] run;

  // Take the neighbor's run on every accepted cell
  always_ff @(posedge clk) begin
    if (shift) begin
      run <= run_in;
    end
  end

  assign run_out = run;

endmodule

### hdl/zswf_out_buf.sv
// Two-entry output stage: result register plus skid register toward the master side.
module zswf_out_buf
  import zswf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  result_t               push_item,
  output logic                  space,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  logic    out_valid;
  logic    skid_valid;
  result_t out_item;
  result_t skid_item;
  logic    pop;

  assign pop   = out_valid && m_tready;
  assign space = !skid_valid;

  // Control: valid flags of both stages
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Payload: move skid forward or load the new result
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_item <= skid_item;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_item <= push_item;
      end else begin
        out_item <= push_item;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_item.matrix_done;
  assign m_tdata  = OUT_DATA_W'({out_item.left_column, out_item.top_row, out_item.status});

  // A waiting skid entry always has a result ahead of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without result register");

  // No new result arrives while the stage is full
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed into full output stage");

  // A taken result moves the skid entry into the result register in the next cycle
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && pop) |=> (!skid_valid && out_valid))
    else $error("skid entry not moved forward");

endmodule

### hdl/zero_square_window_finder.sv
// Top level of the zero square window finder: position control, run update, cell chain.
//
// Usage: matrix cells enter on the slave stream (s_tdata[7:0] = cell_value) in
// row-major order, one transaction per cell. A result leaves on the master stream
// when a cell completes an all-zero square (status found, with the top-left corner)
// and always on the final cell of the matrix (m_tlast = 1, status found, end with
// some found, end none found, or square too large).
// m_tdata, low bit first: status[1:0], top_row[6:2], left_column[11:7], zeros.
// Configuration: cfg_write with cfg_index / cfg_data sets row count, column count
// or square size; a write to any of these three restarts the matrix at row 0, column 0.
// Throughput: one cell per cycle while s_tready is high. The column runs live in a chain
// of MAX_DIM cells that shifts once per accepted cell; the previous row's run of the
// current column is tapped at depth column_count (clamped), so the per-cell run update
// and the horizontal counter finish in the cycle that accepts the cell.
// With the output stage empty, a result is on m_tvalid the cycle after its cell is taken.
// Stall: a two-entry output stage holds results; s_tready drops only when both
// entries are full, and rises the cycle after the receiver takes one.
// Reset: sizes go to 8 x 8 with square size 3, the position and counters clear,
// and the output stage empties. The cell chain needs no clearing.
module zero_square_window_finder
  import zswf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // cell_value[7:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // status[1:0], top_row[6:2], left_column[11:7]
  output logic                  m_tlast    // matrix_done
);

  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] column_count;
  logic [CFG_W-1:0] square_size;

  logic [POS_W-1:0] current_row;
  logic [POS_W-1:0] current_column;
  logic [RUN_W-1:0] adjacent_full_columns;
  logic             any_found;

  logic [CNT_W-1:0] rows;
  logic [CNT_W-1:0] cols;
  logic [POS_W-1:0] tap_sel;
  logic [RUN_W-1:0] chain_q [MAX_DIM];
  logic [RUN_W-1:0] prev_run;
  logic [RUN_W-1:0] run_new;
  logic [RUN_W-1:0] adj_base;
  logic [RUN_W-1:0] adj_new;
  logic             accept;
  logic             restart;
  logic             is_zero;
  logic             usable;
  logic             hit;
  logic             last_row;
  logic             last_col;
  logic             last_cell;
  logic             emit;
  result_t          item;
  logic             space;

  // Configuration registers; a write to an unused index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= ROW_COUNT_RST;
      column_count <= COLUMN_COUNT_RST;
      square_size  <= SQUARE_SIZE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_COUNT:    row_count    <= cfg_data;
        REG_COLUMN_COUNT: column_count <= cfg_data;
        REG_SQUARE_SIZE:  square_size  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign restart = cfg_write && (cfg_index == REG_ROW_COUNT || cfg_index == REG_COLUMN_COUNT
                                 || cfg_index == REG_SQUARE_SIZE);

  // Clamp dimensions into one to MAX_DIM
  always_comb begin
    if (row_count == '0) begin
      rows = CNT_W'(1);
    end else if (32'(row_count) > 32'(MAX_DIM)) begin
      rows = CNT_W'(MAX_DIM);
    end else begin
      rows = CNT_W'(row_count);
    end
    if (column_count == '0) begin
      cols = CNT_W'(1);
    end else if (32'(column_count) > 32'(MAX_DIM)) begin
      cols = CNT_W'(MAX_DIM);
    end else begin
      cols = CNT_W'(column_count);
    end
  end

  assign accept  = s_tvalid && s_tready;
  assign s_tready = space;
  assign is_zero = (s_tdata[CELL_W-1:0] == '0);
  assign tap_sel = POS_W'(cols - CNT_W'(1));

  // Column delay chain: cell 0 takes the fresh run, the tap gives the row above
  genvar gi;
  generate
    for (gi = 0; gi < MAX_DIM; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        zswf_cell u_cell (
          .clk     (clk),
          .shift   (accept),
          .run_in  (run_new),
          .run_out (chain_q[gi])
        );
      end else begin : g_body
        zswf_cell u_cell (
          .clk     (clk),
          .shift   (accept),
          .run_in  (chain_q[gi-1]),
          .run_out (chain_q[gi])
        );
      end
    end
  endgenerate

  // Vertical run and horizontal count of full columns
  always_comb begin
    prev_run = (current_row == '0) ? '0 : chain_q[tap_sel];
    if (!is_zero) begin
      run_new = '0;
    end else if (prev_run < square_size) begin
      run_new = RUN_W'(prev_run + RUN_W'(1));
    end else begin
      run_new = square_size;
    end
    adj_base = (current_column == '0) ? '0 : adjacent_full_columns;
    if (run_new == square_size && square_size != '0) begin
      adj_new = (adj_base < square_size) ? RUN_W'(adj_base + RUN_W'(1)) : square_size;
    end else begin
      adj_new = '0;
    end
  end

  assign usable = (square_size != '0) && (32'(square_size) <= 32'(rows))
                  && (32'(square_size) <= 32'(cols));
  assign hit       = usable && (adj_new == square_size);
  assign last_row  = (32'(current_row) == 32'(rows) - 32'd1);
  assign last_col  = (32'(current_column) == 32'(cols) - 32'd1);
  assign last_cell = last_row && last_col;
  assign emit      = accept && (hit || last_cell);

  // Build the result item
  always_comb begin
    item.matrix_done = last_cell;
    if (hit) begin
      item.status      = STATUS_FOUND;
      item.top_row     = OUT_POS_W'(32'(current_row) + 32'd1 - 32'(square_size));
      item.left_column = OUT_POS_W'(32'(current_column) + 32'd1 - 32'(square_size));
    end else begin
      if (!usable) begin
        item.status = STATUS_TOO_LARGE;
      end else if (any_found) begin
        item.status = STATUS_END_FOUND;
      end else begin
        item.status = STATUS_END_NONE;
      end
      item.top_row     = '0;
      item.left_column = '0;
    end
  end

  // Position, horizontal count and found flag
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      current_row           <= '0;
      current_column        <= '0;
      adjacent_full_columns <= '0;
      any_found             <= 1'b0;
    end else if (accept) begin
      if (last_cell) begin
        current_row           <= '0;
        current_column        <= '0;
        adjacent_full_columns <= '0;
        any_found             <= 1'b0;
      end else begin
        adjacent_full_columns <= adj_new;
        if (hit) begin
          any_found <= 1'b1;
        end
        if (last_col) begin
          current_column <= '0;
          current_row    <= POS_W'(current_row + POS_W'(1));
        end else begin
          current_column <= POS_W'(current_column + POS_W'(1));
        end
      end
    end
  end

  zswf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_item (item),
    .space     (space),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // The final cell always yields a result on the next cycle
  a_final_result: assert property (@(posedge clk) disable iff (rst)
    (accept && last_cell && !restart) |=> m_tvalid)
    else $error("final cell produced no result");

  // The position never leaves the active matrix
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (32'(current_row) < 32'(rows)) && (32'(current_column) < 32'(cols)))
    else $error("position outside active matrix");

  // The horizontal count saturates at the square size
  a_adj_saturates: assert property (@(posedge clk) disable iff (rst)
    adjacent_full_columns <= square_size)
    else $error("full-column count above square size");

endmodule

### tb/tb.sv
// Testbench of the zero square window finder: directed table and random matrices vs. predictor.
`timescale 1ns / 100ps

module tb;
  import zswf_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_CELLS = 640;
  localparam int DRAIN_CYCLES = 8;
  // Index past the last register: a write there changes nothing
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_CELL,
    ROW_CELL_TYPED
  } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [REG_IDX_W-1:0]  idx;
    logic [7:0]            value;
    result_t               typed;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // cell_value[7:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // status[1:0], top_row[6:2], left_column[11:7]
  logic                  m_tlast;        // matrix_done

  // Predictor state: sizes, per-column zero runs, scan position
  logic [CFG_W-1:0] rows_reg = ROW_COUNT_RST;
  logic [CFG_W-1:0] cols_reg = COLUMN_COUNT_RST;
  logic [CFG_W-1:0] side_reg = SQUARE_SIZE_RST;
  int               zero_run [MAX_DIM];
  int               pos_row = 0;
  int               pos_col = 0;
  int               full_cols = 0;
  bit               seen_square = 1'b0;

  result_t   pending_q [$];
  stim_row_t directed_tbl [$];
  int        error_count = 0;
  int        cycle_count = 0;
  int        tx_mode = 1;
  int        rx_mode = 1;
  int        rx_wait = 0;
  int        rx_hold = 0;
  bit        hold_req = 1'b0;

  zero_square_window_finder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int clamp_side(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic void restart_scan();
    pos_row = 0;
    pos_col = 0;
    full_cols = 0;
    seen_square = 1'b0;
  endfunction

  function automatic void apply_write(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    if (idx == REG_ROW_COUNT) rows_reg = val;
    else if (idx == REG_COLUMN_COUNT) cols_reg = val;
    else if (idx == REG_SQUARE_SIZE) side_reg = val;
    else return;
    restart_scan();
  endfunction

  // Advance the scan by one cell; return 1 with the square or end status it yields
  function automatic bit scan_cell(input logic [7:0] v, output result_t res);
    int rows, cols, k, r, c, prev, run, adj;
    bit usable, last, hit;
    rows = clamp_side(rows_reg);
    cols = clamp_side(cols_reg);
    k = int'(side_reg);
    usable = (k >= 1) && (k <= rows) && (k <= cols);
    res = '0;
    // Pull the position back inside a shrunken matrix
    if (pos_row >= rows || pos_col >= cols) restart_scan();
    r = pos_row;
    c = pos_col;
    prev = (r == 0) ? 0 : zero_run[c];
    if (v == 0) run = (prev < k) ? prev + 1 : k;
    else run = 0;
    zero_run[c] = run;
    adj = (c == 0) ? 0 : full_cols;
    if (run == k && k != 0) adj = (adj < k) ? adj + 1 : k;
    else adj = 0;
    full_cols = adj;
    hit = usable && (adj == k);
    last = (r == rows - 1) && (c == cols - 1);
    if (c + 1 < cols) begin
      pos_col = c + 1;
    end else begin
      pos_col = 0;
      pos_row = r + 1;
    end
    if (hit) begin
      seen_square = 1'b1;
      res.status = STATUS_FOUND;
      res.top_row = OUT_POS_W'(r + 1 - k);
      res.left_column = OUT_POS_W'(c + 1 - k);
      res.matrix_done = last;
      if (last) restart_scan();
      return 1'b1;
    end
    if (last) begin
      if (!usable) res.status = STATUS_TOO_LARGE;
      else res.status = seen_square ? STATUS_END_FOUND : STATUS_END_NONE;
      res.matrix_done = 1'b1;
      restart_scan();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Mode 0: no idling, 1: uniform 0..15, 2: mostly back to back
  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 15);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    endcase
  endfunction

  task automatic check_square_result();
    result_t    want;
    logic [1:0] got_status;
    logic [4:0] got_row;
    logic [4:0] got_col;
    got_status = m_tdata[1:0];
    got_row = m_tdata[6:2];
    got_col = m_tdata[11:7];
    if (pending_q.size() == 0) begin
      error_count++;
      $display("%0t unexpected result: expected none, actual tdata=%h tlast=%b",
               $time, m_tdata, m_tlast);
      return;
    end
    want = pending_q.pop_front();
    if (got_status !== want.status) begin
      error_count++;
      $display("%0t status: expected %0d, actual %0d", $time, want.status, got_status);
    end
    if (got_row !== want.top_row) begin
      error_count++;
      $display("%0t top_row: expected %0d, actual %0d", $time, want.top_row, got_row);
    end
    if (got_col !== want.left_column) begin
      error_count++;
      $display("%0t left_column: expected %0d, actual %0d", $time, want.left_column, got_col);
    end
    if (m_tlast !== want.matrix_done) begin
      error_count++;
      $display("%0t matrix_done: expected %b, actual %b", $time, want.matrix_done, m_tlast);
    end
    if (m_tdata[15:12] !== 4'h0) begin
      error_count++;
      $display("%0t tdata pad: expected 0, actual %h", $time, m_tdata[15:12]);
    end
  endtask

  // Take results, idle per transaction, and hold off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_square_result();
        rx_wait = draw_gap(rx_mode);
      end
      if (hold_req) begin
        rx_hold = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one cell after an idle gap and predict on acceptance
  task automatic send_cell(input logic [7:0] v, input bit typed_on, input result_t typed);
    int      gap;
    bit      has;
    result_t res;
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    has = scan_cell(v, res);
    if (typed_on) pending_q.push_back(typed);
    else if (has) pending_q.push_back(res);
  endtask

  // Drop the input and wait until the block is idle
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_write <= 1'b1;
    @(posedge clk);
    apply_write(idx, val);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_sizes(input int r, input int c, input int k);
    settle();
    write_reg(REG_ROW_COUNT, CFG_W'(r));
    write_reg(REG_COLUMN_COUNT, CFG_W'(c));
    write_reg(REG_SQUARE_SIZE, CFG_W'(k));
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return MAX_DIM;
      default: return $urandom_range(MAX_DIM + 1, 63);
    endcase
  endfunction

  // One random setting followed by whole or partial matrices
  task automatic random_phase(output int sent);
    int         r, c, k, per, n, zero_pct;
    logic [7:0] v;
    case ($urandom_range(0, 7))
      0: begin
        r = pick_extreme();
        c = $urandom_range(0, 2);
        k = ($urandom_range(0, 3) == 3) ? 63 : $urandom_range(0, 2);
      end
      1: begin
        r = $urandom_range(0, 2);
        c = pick_extreme();
        k = ($urandom_range(0, 3) == 3) ? 63 : $urandom_range(0, 2);
      end
      2: begin
        r = $urandom_range(1, 4);
        c = $urandom_range(1, 4);
        k = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 63);
      end
      default: begin
        r = $urandom_range(1, 6);
        c = $urandom_range(1, 6);
        k = $urandom_range(1, (r < c) ? r : c);
      end
    endcase
    write_sizes(r, c, k);
    if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, CFG_W'($urandom_range(0, 63)));
    tx_mode = $urandom_range(0, 2);
    rx_mode = $urandom_range(0, 2);
    case ($urandom_range(0, 3))
      0: zero_pct = 50;
      1: zero_pct = 80;
      2: zero_pct = 95;
      default: zero_pct = 100;
    endcase
    per = clamp_side(CFG_W'(r)) * clamp_side(CFG_W'(c));
    // Mostly whole matrices; sometimes cut one short before the next setting
    if ($urandom_range(0, 3) == 0) n = $urandom_range(1, 2 * per);
    else n = (per > 64 ? 1 : $urandom_range(1, 3)) * per;
    for (int i = 0; i < n; i++) begin
      v = ($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255));
      send_cell(v, 1'b0, '0);
    end
    sent = n;
  endtask

  function automatic void add_cfg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.value = 8'(val);
    row.typed = '0;
    directed_tbl.push_back(row);
  endfunction

  function automatic void add_cell(logic [7:0] v);
    stim_row_t row;
    row.kind = ROW_CELL;
    row.idx = '0;
    row.value = v;
    row.typed = '0;
    directed_tbl.push_back(row);
  endfunction

  function automatic void add_typed(logic [7:0] v, status_t st, logic [4:0] tr,
                                    logic [4:0] lc, logic dn);
    stim_row_t row;
    row.kind = ROW_CELL_TYPED;
    row.idx = '0;
    row.value = v;
    row.typed.status = st;
    row.typed.top_row = tr;
    row.typed.left_column = lc;
    row.typed.matrix_done = dn;
    directed_tbl.push_back(row);
  endfunction

  initial begin
    int        done_cells;
    int        n;
    stim_row_t row;

    // Single cell matrix: square of one, no square, bit patterns
    add_cfg(REG_ROW_COUNT, 6'd1);
    add_cfg(REG_COLUMN_COUNT, 6'd1);
    add_cfg(REG_SQUARE_SIZE, 6'd1);
    add_typed(8'h00, STATUS_FOUND, 5'd0, 5'd0, 1'b1);
    add_typed(8'hFF, STATUS_END_NONE, 5'd0, 5'd0, 1'b1);
    add_cell(8'h01);
    add_cell(8'h80);
    // Square size zero and square larger than the matrix
    add_cfg(REG_SQUARE_SIZE, 6'd0);
    add_typed(8'h00, STATUS_TOO_LARGE, 5'd0, 5'd0, 1'b1);
    add_cfg(REG_SQUARE_SIZE, 6'd2);
    add_typed(8'h00, STATUS_TOO_LARGE, 5'd0, 5'd0, 1'b1);
    add_cfg(REG_SPARE, 6'h3F);
    // Square found on the final cell, then a broken one
    add_cfg(REG_ROW_COUNT, 6'd2);
    add_cfg(REG_COLUMN_COUNT, 6'd2);
    add_cell(8'h00);
    add_cell(8'h00);
    add_cell(8'h00);
    add_typed(8'h00, STATUS_FOUND, 5'd0, 5'd0, 1'b1);
    add_cell(8'h00);
    add_cell(8'h00);
    add_cell(8'h00);
    add_cell(8'h55);
    // Row count zero taken as one
    add_cfg(REG_ROW_COUNT, 6'd0);
    add_cfg(REG_COLUMN_COUNT, 6'd2);
    add_cfg(REG_SQUARE_SIZE, 6'd1);
    add_cell(8'hAA);
    add_cell(8'h00);
    // Square inside the matrix, end with some found
    add_cfg(REG_ROW_COUNT, 6'd2);
    add_cfg(REG_COLUMN_COUNT, 6'd3);
    add_cfg(REG_SQUARE_SIZE, 6'd2);
    add_cell(8'h00);
    add_cell(8'h00);
    add_cell(8'h01);
    add_cell(8'h00);
    add_cell(8'h00);
    add_typed(8'h02, STATUS_END_FOUND, 5'd0, 5'd0, 1'b1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int i = 0; i < directed_tbl.size(); i++) begin
      row = directed_tbl[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.idx, row.value[CFG_W-1:0]);
      end else begin
        send_cell(row.value, row.kind == ROW_CELL_TYPED, row.typed);
      end
    end

    done_cells = 0;
    while (done_cells < RANDOM_CELLS) begin
      random_phase(n);
      done_cells += n;
    end

    // Receiver holds off while every cell yields a result: the block fills up
    write_sizes(4, 4, 1);
    tx_mode = 0;
    rx_mode = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) send_cell(8'h00, 1'b0, '0);

    // Widest matrix: the row above is tapped at the far end of the chain
    write_sizes(3, MAX_DIM, 3);
    tx_mode = 2;
    rx_mode = 1;
    for (int i = 0; i < 3 * MAX_DIM; i++) send_cell(8'h00, 1'b0, '0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/zswf_pkg.sv
hdl/zswf_cell.sv
hdl/zswf_out_buf.sv
hdl/zero_square_window_finder.sv
tb/tb.sv
